// ----- sv/mlpsb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mlpsb_pkg
// Shared constants, store layout helpers, sigmoid table and the command and
// status types between the controller and the datapath.
// ----------------------------------------------------------------------------
package mlpsb_pkg;

  localparam int NUM_FEATURES     = 5;
  localparam int DEF_MAX_HIDDEN1  = 32;
  localparam int DEF_MAX_HIDDEN2  = 32;
  localparam int DATA_WIDTH       = 32;
  localparam int ONE_Q            = 65536;
  localparam int SIG_LIMIT        = 500 * 65536;

  // Request kinds on the input tuser bit.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_INFER = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_CLASSIFY = 2'd0;
  localparam logic [1:0] REG_HIDDEN1  = 2'd1;
  localparam logic [1:0] REG_HIDDEN2  = 2'd2;

  // Layer tags carried through the multiply-accumulate pipeline.
  localparam logic [1:0] LAYER_1   = 2'd0;
  localparam logic [1:0] LAYER_2   = 2'd1;
  localparam logic [1:0] LAYER_OUT = 2'd2;

  typedef struct packed {
    logic       wr_req;
    logic       inf_start;
    logic       latch_mean;
    logic       div_start;
    logic       iss_valid;
    logic       iss_bias;
    logic       iss_last;
    logic       sig;
    logic       emit;
    logic [1:0] layer;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } stat_t;

  function automatic int clog2m1(input int v);
    return (v > 1) ? $clog2(v) : 1;
  endfunction

  function automatic int max3(input int a, input int b, input int c);
    int m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // Store layout: means, deviations, W1, b1, W2, b2, Wo, bo.
  function automatic int ofs_dev();
    return NUM_FEATURES;
  endfunction
  function automatic int ofs_w1();
    return 2 * NUM_FEATURES;
  endfunction
  function automatic int ofs_b1(input int a);
    return ofs_w1() + a * NUM_FEATURES;
  endfunction
  function automatic int ofs_w2(input int a);
    return ofs_b1(a) + a;
  endfunction
  function automatic int ofs_b2(input int a, input int b);
    return ofs_w2(a) + b * a;
  endfunction
  function automatic int ofs_wo(input int a, input int b);
    return ofs_b2(a, b) + b;
  endfunction
  function automatic int ofs_bo(input int a, input int b);
    return ofs_wo(a, b) + b;
  endfunction
  function automatic int store_depth(input int a, input int b);
    return ofs_bo(a, b) + 1;
  endfunction

  // sigmoid(k/2) in Q16.16 for k = 0..24.
  function automatic logic [16:0] sig_tab(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0:  v = 17'd32768;
      5'd1:  v = 17'd40793;
      5'd2:  v = 17'd47911;
      5'd3:  v = 17'd53581;
      5'd4:  v = 17'd57724;
      5'd5:  v = 17'd60565;
      5'd6:  v = 17'd62428;
      5'd7:  v = 17'd63615;
      5'd8:  v = 17'd64357;
      5'd9:  v = 17'd64816;
      5'd10: v = 17'd65097;
      5'd11: v = 17'd65269;
      5'd12: v = 17'd65374;
      5'd13: v = 17'd65438;
      5'd14: v = 17'd65476;
      5'd15: v = 17'd65500;
      5'd16: v = 17'd65514;
      5'd17: v = 17'd65523;
      5'd18: v = 17'd65528;
      5'd19: v = 17'd65531;
      5'd20: v = 17'd65533;
      5'd21: v = 17'd65534;
      5'd22: v = 17'd65535;
      5'd23: v = 17'd65535;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sigmoid_q(input logic signed [31:0] x);
    logic [31:0] a;
    logic [16:0] idx;
    logic [14:0] frac;
    logic [16:0] t0;
    logic [16:0] t1;
    logic [31:0] prod;
    logic [16:0] y;
    logic signed [31:0] r;
    a    = x[31] ? (~x + 32'd1) : x;
    idx  = a[31:15];
    frac = a[14:0];
    t0   = sig_tab(idx[4:0]);
    t1   = sig_tab(idx[4:0] + 5'd1);
    prod = 32'(32'(t1 - t0) * {17'd0, frac});
    if (idx >= 17'd24) begin
      y = 17'd65536;
    end else begin
      y = t0 + 17'(prod >> 15);
    end
    if (x < -32'sd32768000) begin
      r = '0;
    end else if (x > 32'sd32768000) begin
      r = 32'sd65536;
    end else if (x[31]) begin
      r = {15'd0, 17'd65536 - y};
    end else begin
      r = {15'd0, y};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/mlp_score_and_best_pick_unit.sv -----
`default_nettype none
// Once an inference is accepted, no new request is taken until its result word is issued;
// the divider (one quotient bit per cycle) and the single shared multiply-accumulate unit
// set the inference rate.
// Reset (rst, synchronous) clears control, the running best and the configuration registers;
// the parameter store holds no reset value and must be loaded before use.
// ----------------------------------------------------------------------------
// mlp_score_and_best_pick_unit
// Two-hidden-layer ReLU network scorer with best-neighbor selection per set.
// ----------------------------------------------------------------------------
module mlp_score_and_best_pick_unit
  import mlpsb_pkg::*;
#(
  parameter int MAX_HIDDEN1 = DEF_MAX_HIDDEN1,
  parameter int MAX_HIDDEN2 = DEF_MAX_HIDDEN2
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // param_addr[10:0], param_value[42:11], feature0..4[202:43], neighbor_id[218:203]
  input  wire  [223:0] s_axis_tdata,
  // req_type
  input  wire  [0:0]   s_axis_tuser,
  input  wire          s_axis_tlast,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // score[31:0], best_neighbor[47:32], best_score[79:48]
  output logic [79:0]  m_axis_tdata,
  // best_valid[0], saturated[1]
  output logic [1:0]   m_axis_tuser,
  input  wire          cfg_we,
  input  wire  [1:0]   cfg_index,
  input  wire  [5:0]   cfg_data
);

  localparam int MAXV = max3(NUM_FEATURES, MAX_HIDDEN1, MAX_HIDDEN2);
  localparam int NW   = clog2m1(MAXV + 1);
  localparam int XW   = clog2m1(MAXV);
  localparam int DW   = clog2m1((MAX_HIDDEN1 > MAX_HIDDEN2) ? MAX_HIDDEN1 : MAX_HIDDEN2);
  localparam int FW   = clog2m1(NUM_FEATURES);
  localparam int PAW  = clog2m1(store_depth(MAX_HIDDEN1, MAX_HIDDEN2));

  logic       classify_mode;
  logic [5:0] hidden1_count;
  logic [5:0] hidden2_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      classify_mode <= 1'b0;
      hidden1_count <= 6'd32;
      hidden2_count <= 6'd32;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CLASSIFY: classify_mode <= cfg_data[0];
        REG_HIDDEN1:  hidden1_count <= cfg_data;
        REG_HIDDEN2:  hidden2_count <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [NW-1:0] h1;
  logic [NW-1:0] h2;

  // Counts outside the legal range are clamped to 1..MAX.
  assign h1 = (hidden1_count == 6'd0) ? NW'(1) :
              ((int'(hidden1_count) > MAX_HIDDEN1) ? NW'(MAX_HIDDEN1) : NW'(hidden1_count));
  assign h2 = (hidden2_count == 6'd0) ? NW'(1) :
              ((int'(hidden2_count) > MAX_HIDDEN2) ? NW'(MAX_HIDDEN2) : NW'(hidden2_count));

  cmd_t           cmd;
  stat_t          stat;
  logic [PAW-1:0] rd_addr;
  logic [XW-1:0]  x_idx;
  logic [DW-1:0]  dst;
  logic [FW-1:0]  feat_idx;
  logic [NUM_FEATURES-1:0][31:0] in_feat;

  assign in_feat = s_axis_tdata[43 +: NUM_FEATURES * 32];

  mlpsb_ctrl #(.MAX_HIDDEN1(MAX_HIDDEN1), .MAX_HIDDEN2(MAX_HIDDEN2)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_kind  (s_axis_tuser[0]),
    .in_ready (s_axis_tready),
    .h1       (h1),
    .h2       (h2),
    .stat     (stat),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .x_idx    (x_idx),
    .dst      (dst),
    .feat_idx (feat_idx)
  );

  mlpsb_dp #(.MAX_HIDDEN1(MAX_HIDDEN1), .MAX_HIDDEN2(MAX_HIDDEN2)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .rd_addr       (rd_addr),
    .x_idx         (x_idx),
    .dst           (dst),
    .feat_idx      (feat_idx),
    .param_addr    (s_axis_tdata[10:0]),
    .param_value   (s_axis_tdata[42:11]),
    .in_feat       (in_feat),
    .in_id         (s_axis_tdata[218:203]),
    .in_last       (s_axis_tlast),
    .classify_mode (classify_mode),
    .stat          (stat),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_data      (m_axis_tdata),
    .out_user      (m_axis_tuser)
  );

  // A word without a completed set carries zero best fields.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[79:32] == 48'd0))
    else $error("best fields not cleared on a word that ends no set");

  // Once an inference is taken the input side closes until it finishes.
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == REQ_INFER)) |=> !s_axis_tready)
    else $error("input accepted during an inference");

  // No result word is pending right after reset.
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule
`default_nettype wire

// ----- sv/mlpsb_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mlpsb_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module mlpsb_ram
  import mlpsb_pkg::*;
#(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire                        clk,
  input  wire                        we,
  input  wire [clog2m1(DEPTH)-1:0]   waddr,
  input  wire [WIDTH-1:0]            wdata,
  input  wire [clog2m1(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- sv/mlpsb_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mlpsb_ctrl
// Sequencer: normalizes the features one by one, then walks every neuron of
// both hidden layers and the output neuron through the shared MAC pipeline.
// ----------------------------------------------------------------------------
module mlpsb_ctrl
  import mlpsb_pkg::*;
#(
  parameter int MAX_HIDDEN1 = DEF_MAX_HIDDEN1,
  parameter int MAX_HIDDEN2 = DEF_MAX_HIDDEN2,
  localparam int MAXV = max3(NUM_FEATURES, MAX_HIDDEN1, MAX_HIDDEN2),
  localparam int NW   = clog2m1(MAXV + 1),
  localparam int XW   = clog2m1(MAXV),
  localparam int DW   = clog2m1((MAX_HIDDEN1 > MAX_HIDDEN2) ? MAX_HIDDEN1 : MAX_HIDDEN2),
  localparam int FW   = clog2m1(NUM_FEATURES),
  localparam int PAW  = clog2m1(store_depth(MAX_HIDDEN1, MAX_HIDDEN2))
) (
  input  wire            clk,
  input  wire            rst,
  input  wire            in_valid,
  input  wire            in_kind,
  output logic           in_ready,
  input  wire [NW-1:0]   h1,
  input  wire [NW-1:0]   h2,
  input  stat_t          stat,
  output cmd_t           cmd,
  output logic [PAW-1:0] rd_addr,
  output logic [XW-1:0]  x_idx,
  output logic [DW-1:0]  dst,
  output logic [FW-1:0]  feat_idx
);

  localparam int OFS_B1 = ofs_b1(MAX_HIDDEN1);
  localparam int OFS_W2 = ofs_w2(MAX_HIDDEN1);
  localparam int OFS_B2 = ofs_b2(MAX_HIDDEN1, MAX_HIDDEN2);
  localparam int OFS_WO = ofs_wo(MAX_HIDDEN1, MAX_HIDDEN2);
  localparam int OFS_BO = ofs_bo(MAX_HIDDEN1, MAX_HIDDEN2);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_NRDM  = 4'd1;
  localparam logic [3:0] S_NRDD  = 4'd2;
  localparam logic [3:0] S_NLD   = 4'd3;
  localparam logic [3:0] S_NDIV  = 4'd4;
  localparam logic [3:0] S_BIAS  = 4'd5;
  localparam logic [3:0] S_MAC   = 4'd6;
  localparam logic [3:0] S_DRAIN = 4'd7;
  localparam logic [3:0] S_SIG   = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  logic [3:0]     state;
  logic [FW-1:0]  fi;
  logic [NW-1:0]  ni;
  logic [NW-1:0]  j;
  logic [PAW-1:0] wptr;
  logic [PAW-1:0] rowbase;
  logic [1:0]     layer;
  logic [1:0]     drain_cnt;
  logic [NW-1:0]  n_in;
  logic [NW-1:0]  n_out;
  logic [PAW-1:0] bias_addr;
  logic           mac_last;
  logic           neuron_last;

  always_comb begin
    unique case (layer)
      LAYER_1: begin
        n_in      = NW'(NUM_FEATURES);
        n_out     = h1;
        bias_addr = PAW'(OFS_B1 + int'(ni));
      end
      LAYER_2: begin
        n_in      = h1;
        n_out     = h2;
        bias_addr = PAW'(OFS_B2 + int'(ni));
      end
      default: begin
        n_in      = h2;
        n_out     = NW'(1);
        bias_addr = PAW'(OFS_BO);
      end
    endcase
  end

  assign mac_last    = (j == n_in - NW'(1));
  assign neuron_last = (ni == n_out - NW'(1));
  assign dst         = ni[DW-1:0];
  assign feat_idx    = fi;
  assign x_idx       = j[XW-1:0];

  always_comb begin
    cmd       = '0;
    cmd.layer = layer;
    rd_addr   = '0;
    in_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.wr_req    = in_valid && (in_kind == REQ_WRITE);
        cmd.inf_start = in_valid && (in_kind == REQ_INFER);
      end
      S_NRDM: rd_addr = PAW'(int'(fi));
      S_NRDD: begin
        cmd.latch_mean = 1'b1;
        rd_addr        = PAW'(ofs_dev() + int'(fi));
      end
      S_NLD:  cmd.div_start = 1'b1;
      S_BIAS: begin
        cmd.iss_valid = 1'b1;
        cmd.iss_bias  = 1'b1;
        rd_addr       = bias_addr;
      end
      S_MAC: begin
        cmd.iss_valid = 1'b1;
        cmd.iss_last  = mac_last;
        rd_addr       = wptr;
      end
      S_SIG:  cmd.sig  = 1'b1;
      S_FIN:  cmd.emit = stat.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fi        <= '0;
      ni        <= '0;
      j         <= '0;
      wptr      <= '0;
      rowbase   <= '0;
      layer     <= LAYER_1;
      drain_cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.inf_start) begin
            fi    <= '0;
            state <= S_NRDM;
          end
        end
        S_NRDM: state <= S_NRDD;
        S_NRDD: state <= S_NLD;
        S_NLD:  state <= S_NDIV;
        S_NDIV: begin
          if (!stat.div_busy) begin
            if (fi == FW'(NUM_FEATURES - 1)) begin
              layer <= LAYER_1;
              ni    <= '0;
              wptr  <= PAW'(ofs_w1());
              state <= S_BIAS;
            end else begin
              fi    <= fi + FW'(1);
              state <= S_NRDM;
            end
          end
        end
        S_BIAS: begin
          j     <= '0;
          state <= S_MAC;
        end
        S_MAC: begin
          j <= j + NW'(1);
          // Second-layer rows are MAX_HIDDEN1 words apart in the store.
          if (mac_last && !neuron_last && (layer == LAYER_2)) begin
            rowbase <= rowbase + PAW'(MAX_HIDDEN1);
            wptr    <= rowbase + PAW'(MAX_HIDDEN1);
          end else begin
            wptr <= wptr + PAW'(1);
          end
          if (mac_last) begin
            if (neuron_last) begin
              drain_cnt <= 2'd2;
              state     <= S_DRAIN;
            end else begin
              ni    <= ni + NW'(1);
              state <= S_BIAS;
            end
          end
        end
        S_DRAIN: begin
          if (drain_cnt != 2'd0) begin
            drain_cnt <= drain_cnt - 2'd1;
          end else begin
            ni <= '0;
            unique case (layer)
              LAYER_1: begin
                layer   <= LAYER_2;
                wptr    <= PAW'(OFS_W2);
                rowbase <= PAW'(OFS_W2);
                state   <= S_BIAS;
              end
              LAYER_2: begin
                layer <= LAYER_OUT;
                wptr  <= PAW'(OFS_WO);
                state <= S_BIAS;
              end
              default: state <= S_SIG;
            endcase
          end
        end
        S_SIG: state <= S_FIN;
        S_FIN: begin
          if (stat.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sv/mlpsb_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mlpsb_dp
// Datapath: parameter store, radix-2 normalizing divider, shared
// multiply-accumulate pipeline with saturation, layer scratch memories,
// sigmoid, best-of-set tracking and the output register.
// ----------------------------------------------------------------------------
module mlpsb_dp
  import mlpsb_pkg::*;
#(
  parameter int MAX_HIDDEN1 = DEF_MAX_HIDDEN1,
  parameter int MAX_HIDDEN2 = DEF_MAX_HIDDEN2,
  localparam int MAXV  = max3(NUM_FEATURES, MAX_HIDDEN1, MAX_HIDDEN2),
  localparam int XW    = clog2m1(MAXV),
  localparam int DW    = clog2m1((MAX_HIDDEN1 > MAX_HIDDEN2) ? MAX_HIDDEN1 : MAX_HIDDEN2),
  localparam int FW    = clog2m1(NUM_FEATURES),
  localparam int DEPTH = store_depth(MAX_HIDDEN1, MAX_HIDDEN2),
  localparam int PAW   = clog2m1(DEPTH)
) (
  input  wire                                clk,
  input  wire                                rst,
  input  cmd_t                               cmd,
  input  wire [PAW-1:0]                      rd_addr,
  input  wire [XW-1:0]                       x_idx,
  input  wire [DW-1:0]                       dst,
  input  wire [FW-1:0]                       feat_idx,
  input  wire [10:0]                         param_addr,
  input  wire [31:0]                         param_value,
  input  wire [NUM_FEATURES-1:0][31:0]       in_feat,
  input  wire [15:0]                         in_id,
  input  wire                                in_last,
  input  wire                                classify_mode,
  output stat_t                              stat,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [79:0]                        out_data,
  output logic [1:0]                         out_user
);

  localparam int A1W = clog2m1(MAX_HIDDEN1);
  localparam int A2W = clog2m1(MAX_HIDDEN2);

  // ---------------- parameter store ----------------
  logic        p_we;
  logic [31:0] p_wdata;
  logic [31:0] p_rdata;
  logic        is_dev;

  assign is_dev  = ({21'd0, param_addr} >= 32'(ofs_dev())) &&
                   ({21'd0, param_addr} < 32'(ofs_dev() + NUM_FEATURES));
  assign p_we    = cmd.wr_req && ({21'd0, param_addr} < 32'(DEPTH));
  // A deviation of zero or less would not divide; it is stored as 1.0.
  assign p_wdata = (is_dev && ($signed(param_value) <= 32'sd0)) ? 32'(ONE_Q) : param_value;

  mlpsb_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (p_we),
    .waddr (PAW'(param_addr)),
    .wdata (p_wdata),
    .raddr (rd_addr),
    .rdata (p_rdata)
  );

  // ---------------- latched item ----------------
  logic [NUM_FEATURES-1:0][31:0] feat_in;
  logic [15:0]                   id_r;
  logic                          last_r;

  always_ff @(posedge clk) begin
    if (cmd.inf_start) begin
      feat_in <= in_feat;
      id_r    <= in_id;
      last_r  <= in_last;
    end
  end

  // ---------------- normalizing divider ----------------
  logic signed [32:0] diff;
  logic [48:0]        dq;
  logic [30:0]        drem;
  logic [30:0]        dvsr;
  logic               dneg;
  logic [5:0]         dcnt;
  logic               div_busy;
  logic [31:0]        rem_sh;
  logic               ge;
  logic [31:0]        rem_sub;
  logic [32:0]        diff_abs;
  logic               div_fin;
  logic               div_sat;
  logic [31:0]        div_val;
  logic [31:0]        feat [NUM_FEATURES];

  assign rem_sh   = {drem, dq[48]};
  assign rem_sub  = rem_sh - {1'b0, dvsr};
  assign ge       = (rem_sh >= {1'b0, dvsr});
  assign diff_abs = diff[32] ? 33'(-diff) : 33'(diff);
  assign div_fin  = div_busy && (dcnt == 6'd0);

  always_comb begin
    div_sat = 1'b0;
    if (!dneg) begin
      div_val = dq[31:0];
      if (dq[48:31] != '0) begin
        div_sat = 1'b1;
        div_val = 32'h7fff_ffff;
      end
    end else begin
      div_val = 32'(~dq[31:0] + 32'd1);
      if ((dq[48:32] != '0) || (dq[31] && (dq[30:0] != '0))) begin
        div_sat = 1'b1;
        div_val = 32'h8000_0000;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (cmd.div_start) begin
      div_busy <= 1'b1;
    end else if (div_fin) begin
      div_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_mean) begin
      diff <= $signed({feat_in[feat_idx][31], feat_in[feat_idx]}) -
              $signed({p_rdata[31], p_rdata});
    end
    if (cmd.div_start) begin
      dq   <= {diff_abs, 16'd0};
      dneg <= diff[32];
      dvsr <= p_rdata[30:0];
      drem <= '0;
      dcnt <= 6'd49;
    end else if (div_busy && (dcnt != 6'd0)) begin
      drem <= ge ? rem_sub[30:0] : rem_sh[30:0];
      dq   <= {dq[47:0], ge};
      dcnt <= dcnt - 6'd1;
    end
    if (div_fin) begin
      feat[feat_idx] <= div_val;
    end
  end

  assign stat.div_busy = div_busy;

  // ---------------- MAC pipeline ----------------
  logic               s1_valid, s1_bias, s1_last;
  logic [1:0]         s1_layer;
  logic [DW-1:0]      s1_dst;
  logic [31:0]        s1_feat;
  logic [31:0]        l1_rdata;
  logic [31:0]        l2_rdata;
  logic [31:0]        x_val;
  logic               s2_valid, s2_bias, s2_last;
  logic [1:0]         s2_layer;
  logic [DW-1:0]      s2_dst;
  logic signed [63:0] s2_prod;
  logic signed [63:0] acc;
  logic signed [63:0] sum;
  logic               add_ovf;
  logic               s3_done;
  logic [1:0]         s3_layer;
  logic [DW-1:0]      s3_dst;
  logic [47:0]        acc_hi;
  logic               nar_sat;
  logic [31:0]        nval;
  logic [31:0]        relu_val;
  logic signed [31:0] raw_score;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_done  <= 1'b0;
    end else begin
      s1_valid <= cmd.iss_valid;
      s2_valid <= s1_valid;
      s3_done  <= s2_valid && s2_last && !s2_bias;
    end
  end

  always_ff @(posedge clk) begin
    s1_bias  <= cmd.iss_bias;
    s1_last  <= cmd.iss_last;
    s1_layer <= cmd.layer;
    s1_dst   <= dst;
    s1_feat  <= ({{(32 - XW){1'b0}}, x_idx} < 32'(NUM_FEATURES)) ? feat[x_idx[FW-1:0]] : '0;
    s2_bias  <= s1_bias;
    s2_last  <= s1_last;
    s2_layer <= s1_layer;
    s2_dst   <= s1_dst;
    if (s1_bias) begin
      s2_prod <= {{16{p_rdata[31]}}, p_rdata, 16'd0};
    end else begin
      s2_prod <= $signed(p_rdata) * $signed(x_val);
    end
    s3_layer <= s2_layer;
    s3_dst   <= s2_dst;
    if (s2_valid) begin
      if (s2_bias) begin
        acc <= s2_prod;
      end else if (add_ovf) begin
        acc <= acc[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
        acc <= sum;
      end
    end
    if (s3_done && (s3_layer == LAYER_OUT)) begin
      raw_score <= nval;
    end
  end

  always_comb begin
    case (s1_layer)
      LAYER_1: x_val = s1_feat;
      LAYER_2: x_val = l1_rdata;
      default: x_val = l2_rdata;
    endcase
  end

  assign sum     = acc + s2_prod;
  assign add_ovf = s2_valid && !s2_bias && (acc[63] == s2_prod[63]) && (sum[63] != acc[63]);

  // Arithmetic shift right by 16 is the floor division; then narrow to 32 bits.
  assign acc_hi = acc[63:16];
  always_comb begin
    nar_sat = 1'b0;
    nval    = acc_hi[31:0];
    if (acc_hi[47:31] != {17{acc_hi[47]}}) begin
      nar_sat = s3_done;
      nval    = acc_hi[47] ? 32'h8000_0000 : 32'h7fff_ffff;
    end
  end
  assign relu_val = nval[31] ? 32'd0 : nval;

  mlpsb_ram #(.WIDTH(32), .DEPTH(MAX_HIDDEN1)) u_l1 (
    .clk   (clk),
    .we    (s3_done && (s3_layer == LAYER_1)),
    .waddr (s3_dst[A1W-1:0]),
    .wdata (relu_val),
    .raddr (x_idx[A1W-1:0]),
    .rdata (l1_rdata)
  );

  mlpsb_ram #(.WIDTH(32), .DEPTH(MAX_HIDDEN2)) u_l2 (
    .clk   (clk),
    .we    (s3_done && (s3_layer == LAYER_2)),
    .waddr (s3_dst[A2W-1:0]),
    .wdata (relu_val),
    .raddr (x_idx[A2W-1:0]),
    .rdata (l2_rdata)
  );

  // ---------------- saturation flag ----------------
  logic sat;

  always_ff @(posedge clk) begin
    if (cmd.inf_start) begin
      sat <= 1'b0;
    end else begin
      sat <= sat | (div_fin && div_sat) | add_ovf | nar_sat;
    end
  end

  // ---------------- score, best of set, output word ----------------
  logic signed [31:0] score_r;
  logic signed [31:0] best_score;
  logic [15:0]        best_id;
  logic               started;
  logic               better;
  logic signed [31:0] cur_score;
  logic [15:0]        cur_id;

  always_ff @(posedge clk) begin
    if (cmd.sig) begin
      score_r <= classify_mode ? sigmoid_q(raw_score) : raw_score;
    end
  end

  assign better    = !started || (score_r > best_score);
  assign cur_score = better ? score_r : best_score;
  assign cur_id    = better ? id_r : best_id;

  always_ff @(posedge clk) begin
    if (rst) begin
      best_score <= {1'b1, 31'd0};
      best_id    <= '0;
      started    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
        if (last_r) begin
          best_score <= {1'b1, 31'd0};
          best_id    <= '0;
          started    <= 1'b0;
        end else begin
          best_score <= cur_score;
          best_id    <= cur_id;
          started    <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data[31:0] <= score_r;
      out_user[1]    <= sat;
      if (last_r) begin
        out_data[47:32] <= cur_id;
        out_data[79:48] <= cur_score;
        out_user[0]     <= 1'b1;
      end else begin
        out_data[79:32] <= '0;
        out_user[0]     <= 1'b0;
      end
    end
  end

  assign stat.out_free = !out_valid || out_ready;

endmodule
`default_nettype wire

// ----- tb/sv/mlp_score_and_best_pick_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mlp_score_and_best_pick_unit_tb
// Loads the whole parameter store, then streams inference and parameter words
// under several network sizes and output modes. A scoreboard predicts every
// score, best pick and saturation flag and compares them with the block.
// ----------------------------------------------------------------------------
module mlp_score_and_best_pick_unit_tb;
  import mlpsb_pkg::*;

  localparam int PAR_DEPTH = 1291;
  localparam int A_MEAN = 0;
  localparam int A_DEV  = 5;
  localparam int A_W1   = 10;
  localparam int A_B1   = 170;
  localparam int A_W2   = 202;
  localparam int A_B2   = 1226;
  localparam int A_WO   = 1258;
  localparam int A_BO   = 1290;
  localparam longint Q_ONE = 65536;
  localparam logic [1:0] REG_SPARE = 2'd3;

  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic              kind;
    logic [10:0]       addr;
    logic [31:0]       value;
    logic signed [31:0] feat [5];
    logic [15:0]       id;
    logic              last;
  } word_t;

  typedef struct packed {
    logic [31:0] score;
    logic        best_valid;
    logic [15:0] best_id;
    logic [31:0] best_score;
    logic        sat;
  } result_t;

  class score_board;
    logic signed [31:0] store [PAR_DEPTH];
    bit         sig_on;
    bit [5:0]   h1_reg, h2_reg;
    longint     best_val;
    bit [15:0]  best_id;
    bit         set_open;
    bit         sat;
    result_t    pending [$];
    int         errors, n_infer, n_sets, n_sat;

    function new();
      sig_on = 0; h1_reg = 32; h2_reg = 32;
      best_val = 0; best_id = 0; set_open = 0;
      errors = 0; n_infer = 0; n_sets = 0; n_sat = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [5:0] v);
      case (idx)
        REG_CLASSIFY: sig_on = v[0];
        REG_HIDDEN1:  h1_reg = v;
        REG_HIDDEN2:  h2_reg = v;
        default: ;
      endcase
    endfunction

    function longint narrow(longint v);
      if (v > 64'sd2147483647) begin
        sat = 1; return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        sat = 1; return -64'sd2147483648;
      end
      return v;
    endfunction

    function longint sat_add(longint a, longint b);
      longint s;
      s = a + b;
      // Same-sign operands with a flipped result sign means the sum wrapped.
      if (a[63] == b[63] && s[63] != a[63]) begin
        sat = 1;
        return a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end
      return s;
    endfunction

    function longint neuron(int wb, int bb, longint xin [32], int n);
      longint acc;
      acc = longint'(store[bb]) * Q_ONE;
      for (int j = 0; j < n; j++)
        acc = sat_add(acc, longint'(store[wb + j]) * xin[j]);
      return narrow(acc >>> 16);
    endfunction

    function longint squash(longint x);
      longint tab [25] = '{32768, 40793, 47911, 53581, 57724, 60565, 62428, 63615,
                           64357, 64816, 65097, 65269, 65374, 65438, 65476, 65500,
                           65514, 65523, 65528, 65531, 65533, 65534, 65535, 65535,
                           65536};
      longint a, y, idx, frac;
      if (x < -500 * Q_ONE) return 0;
      if (x > 500 * Q_ONE) return Q_ONE;
      a = (x < 0) ? -x : x;
      idx = a >> 15;
      frac = a & 32767;
      if (idx >= 24) y = Q_ONE;
      else y = tab[idx] + (((tab[idx + 1] - tab[idx]) * frac) >> 15);
      return (x < 0) ? Q_ONE - y : y;
    endfunction

    function void note_word(word_t w);
      longint nf [32];
      longint l1 [32];
      longint l2 [32];
      longint num, dev, score, v;
      int h1, h2;
      result_t r;
      if (w.kind == REQ_WRITE) begin
        if (w.addr < PAR_DEPTH) begin
          if (w.addr >= A_DEV && w.addr < A_DEV + 5 && $signed(w.value) <= 0)
            store[w.addr] = Q_ONE;
          else
            store[w.addr] = w.value;
        end
        return;
      end
      sat = 0;
      h1 = (h1_reg == 0) ? 1 : (h1_reg > 32) ? 32 : h1_reg;
      h2 = (h2_reg == 0) ? 1 : (h2_reg > 32) ? 32 : h2_reg;
      for (int i = 0; i < 32; i++) begin
        nf[i] = 0; l1[i] = 0; l2[i] = 0;
      end
      for (int i = 0; i < 5; i++) begin
        num = (longint'(w.feat[i]) - longint'(store[A_MEAN + i])) * Q_ONE;
        dev = store[A_DEV + i];
        if (dev == 0)
          nf[i] = (num > 0) ? narrow(64'h7FFF_FFFF_FFFF_FFFF) :
                  (num < 0) ? narrow(64'h8000_0000_0000_0000) : 0;
        else
          nf[i] = narrow(num / dev);
      end
      for (int i = 0; i < h1; i++) begin
        v = neuron(A_W1 + i * 5, A_B1 + i, nf, 5);
        l1[i] = (v < 0) ? 0 : v;
      end
      for (int i = 0; i < h2; i++) begin
        v = neuron(A_W2 + i * 32, A_B2 + i, l1, h1);
        l2[i] = (v < 0) ? 0 : v;
      end
      score = neuron(A_WO, A_BO, l2, h2);
      if (sig_on) score = squash(score);
      if (!set_open || score > best_val) begin
        best_val = score; best_id = w.id; set_open = 1;
      end
      r.score = score[31:0];
      r.sat = sat;
      if (w.last) begin
        r.best_valid = 1; r.best_id = best_id; r.best_score = best_val[31:0];
        best_val = 0; best_id = 0; set_open = 0;
        n_sets++;
      end else begin
        r.best_valid = 0; r.best_id = 0; r.best_score = 0;
      end
      n_infer++;
      if (sat) n_sat++;
      pending.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word %h", $realtime, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.score !== exp_r.score) begin
        $display("%0t: score expected %h actual %h", $realtime, exp_r.score, got.score);
        errors++;
      end
      if (got.best_valid !== exp_r.best_valid) begin
        $display("%0t: best_valid expected %b actual %b", $realtime,
                 exp_r.best_valid, got.best_valid);
        errors++;
      end
      if (got.best_id !== exp_r.best_id) begin
        $display("%0t: best_neighbor expected %h actual %h", $realtime,
                 exp_r.best_id, got.best_id);
        errors++;
      end
      if (got.best_score !== exp_r.best_score) begin
        $display("%0t: best_score expected %h actual %h", $realtime,
                 exp_r.best_score, got.best_score);
        errors++;
      end
      if (got.sat !== exp_r.sat) begin
        $display("%0t: saturated expected %b actual %b", $realtime, exp_r.sat, got.sat);
        errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [223:0] s_axis_tdata;
  logic [0:0]   s_axis_tuser;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [79:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [5:0]   cfg_data;

  score_board sb;
  int idle_mode;
  int stall_cycles;

  mlp_score_and_best_pick_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Receiver back-pressure, changed on the falling edge.
  always @(negedge clk) begin
    if (idle_mode == IDLE_RECV)
      m_axis_tready <= ($urandom_range(99) >= 80);
    else if (idle_mode == IDLE_BOTH)
      m_axis_tready <= ($urandom_range(99) >= 11);
    else
      m_axis_tready <= 1'b1;
  end

  // Input and output monitors plus the stall watchdog.
  always @(posedge clk) begin
    word_t w;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        w.kind  = s_axis_tuser[0];
        w.addr  = s_axis_tdata[10:0];
        w.value = s_axis_tdata[42:11];
        for (int i = 0; i < 5; i++)
          w.feat[i] = s_axis_tdata[43 + 32 * i +: 32];
        w.id   = s_axis_tdata[218:203];
        w.last = s_axis_tlast;
        sb.note_word(w);
      end
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result({m_axis_tdata[31:0], m_axis_tuser[0], m_axis_tdata[47:32],
                         m_axis_tdata[79:48], m_axis_tuser[1]});
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("mlp_score_and_best_pick_unit verification failed");
        $finish;
      end
    end
  end

  task automatic send_word(word_t w);
    int gap_pct;
    gap_pct = (idle_mode == IDLE_SEND) ? 80 : (idle_mode == IDLE_BOTH) ? 11 : 0;
    while ($urandom_range(99) < gap_pct) @(negedge clk);
    s_axis_tuser  = w.kind;
    s_axis_tlast  = w.last;
    s_axis_tdata  = {5'd0, w.id, w.feat[4], w.feat[3], w.feat[2], w.feat[1], w.feat[0],
                     w.value, w.addr};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic put_param(int addr, logic [31:0] v);
    word_t w;
    w.kind = REQ_WRITE; w.addr = 11'(addr); w.value = v;
    for (int i = 0; i < 5; i++) w.feat[i] = $urandom;
    w.id = 16'($urandom); w.last = 1'($urandom);
    send_word(w);
  endtask

  task automatic infer(logic signed [31:0] f0, logic signed [31:0] f1,
                       logic signed [31:0] f2, logic signed [31:0] f3,
                       logic signed [31:0] f4, logic [15:0] id, logic last);
    word_t w;
    w.kind = REQ_INFER; w.addr = 11'($urandom); w.value = $urandom;
    w.feat[0] = f0; w.feat[1] = f1; w.feat[2] = f2; w.feat[3] = f3; w.feat[4] = f4;
    w.id = id; w.last = last;
    send_word(w);
  endtask

  // Waits until every result is back; writes produce nothing, so a short
  // margin afterwards is enough before touching the registers.
  task automatic drain();
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [5:0] v);
    cfg_index = idx;
    cfg_data  = v;
    cfg_we    = 1'b1;
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [31:0] pick_feature();
    if ($urandom_range(9) < 7)
      return $urandom_range(1048576) - 524288;
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_weight(int addr);
    if (addr >= A_DEV && addr < A_DEV + 5)
      return $urandom_range(32768, 262144);
    return $urandom_range(131072) - 65536;
  endfunction

  task automatic random_word();
    int addr;
    logic [31:0] v;
    if ($urandom_range(99) < 15) begin
      case ($urandom_range(3))
        0: addr = $urandom_range(2047);
        1: addr = A_DEV + $urandom_range(4);
        default: addr = $urandom_range(PAR_DEPTH - 1);
      endcase
      v = pick_weight(addr);
      if ($urandom_range(9) == 0) v = $urandom;
      put_param(addr, v);
    end else begin
      infer(pick_feature(), pick_feature(), pick_feature(), pick_feature(),
            pick_feature(), 16'($urandom), ($urandom_range(3) == 0));
    end
  endtask

  initial begin
    int modes [10]  = '{1, 0, 1, 0, 1, 0, 1, 0, 1, 0};
    int h1s [10]    = '{0, 1, 4, 63, 8, 3, 32, 5, 2, 6};
    int h2s [10]    = '{63, 1, 3, 2, 8, 6, 32, 1, 2, 4};
    int idles [10]  = '{IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE, IDLE_SEND,
                        IDLE_RECV, IDLE_BOTH, IDLE_NONE, IDLE_RECV, IDLE_SEND};
    int counts [10] = '{40, 50, 50, 30, 50, 50, 15, 50, 50, 45};
    sb = new();
    idle_mode = IDLE_NONE;
    stall_cycles = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_CLASSIFY;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Every store entry is written before the first inference.
    for (int a = 0; a < PAR_DEPTH; a++)
      put_param(a, (a < A_DEV) ? ($urandom_range(524288) - 262144) : pick_weight(a));

    // Directed: small deviations, writes past the store, field extremes, ties.
    put_param(A_DEV, 32'd0);
    put_param(A_DEV + 1, 32'h8000_0000);
    put_param(PAR_DEPTH, $urandom);
    put_param(2047, $urandom);
    infer(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
          32'sh7FFF_FFFF, 16'hFFFF, 1'b0);
    infer(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
          32'sh8000_0000, 16'h0000, 1'b1);
    infer(0, 0, 0, 0, 0, 16'h1234, 1'b1);
    infer(65536, -65536, 32768, 0, 12345, 16'd5, 1'b0);
    infer(65536, -65536, 32768, 0, 12345, 16'd6, 1'b1);
    // A huge weight and bias push the accumulators into saturation.
    put_param(A_W1, 32'h7FFF_FFFF);
    put_param(A_BO, 32'h7FFF_FFFF);
    infer(32'sh7FFF_FFFF, 0, 0, 0, 0, 16'hA5A5, 1'b1);
    put_param(A_BO, 32'h8000_0000);
    infer(32'sh7FFF_FFFF, 0, 0, 0, 0, 16'h5A5A, 1'b1);
    drain();
    set_reg(REG_CLASSIFY, 6'd1);
    set_reg(REG_SPARE, 6'h3F);
    infer(32'sh7FFF_FFFF, 0, 0, 0, 0, 16'h0001, 1'b0);
    put_param(A_BO, 32'h0000_0000);
    put_param(A_W1, 32'h0001_0000);
    infer(0, 0, 0, 0, 0, 16'h0002, 1'b0);
    infer(32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 0, 16'h0003, 1'b1);
    drain();

    for (int p = 0; p < 10; p++) begin
      set_reg(REG_CLASSIFY, 6'(modes[p]));
      set_reg(REG_HIDDEN1, 6'(h1s[p]));
      set_reg(REG_HIDDEN2, 6'(h2s[p]));
      idle_mode = idles[p];
      for (int k = 0; k < counts[p]; k++) begin
        random_word();
        // Now and then the sender holds off until the pipeline is empty.
        if (p == 7 && $urandom_range(3) == 0)
          while (sb.pending.size() > 0) @(negedge clk);
      end
      drain();
    end

    repeat (200) @(negedge clk);
    $display("Covered %0d inferences in %0d completed sets, %0d with saturation,",
             sb.n_infer, sb.n_sets, sb.n_sat);
    $display("over ten size and output-mode settings with varied idling on both sides.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("mlp_score_and_best_pick_unit verification clean");
    end else begin
      if (sb.pending.size() != 0)
        $display("%0t: %0d expected results never arrived", $realtime, sb.pending.size());
      $display("mlp_score_and_best_pick_unit verification failed");
    end
    $finish;
  end

endmodule
